// ===== hdl/pmvi_pkg.sv =====
`timescale 1ns / 1ps

package pmvi_pkg;

  // Vector and register word width
  localparam int W = 32;
  // Fraction bits of the frame time
  localparam int DT_BITS = 16;
  localparam int FRAC_BITS_DEF = 16;
  // Dividend width of the shared divider
  localparam int NUM_W = 2 * W;
  // Gravity in millionths, speed limit in whole units
  localparam longint unsigned GRAVITY_MICRO = 64'd9806650;
  localparam longint unsigned MAX_SPEED_DEF = 64'd1000;

  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MASS       = 3'd0,
    CFG_DRAG       = 3'd1,
    CFG_MAX_SPEED  = 3'd2,
    CFG_GRAVITY_ON = 3'd3,
    CFG_GRAVITY    = 3'd4,
    CFG_KINEMATIC  = 3'd5,
    CFG_ACTIVE     = 3'd6
  } cfg_idx_e;

  typedef logic [1:0] comp_t;
  localparam comp_t COMP_FIRST = 2'd0;
  localparam comp_t COMP_Y     = 2'd1;
  localparam comp_t COMP_LAST  = 2'd2;

  typedef enum logic [2:0] {
    MUL_ACC_DT   = 3'd0,
    MUL_VEL_SQ   = 3'd1,
    MUL_DRAG_DT  = 3'd2,
    MUL_LIM_DT   = 3'd3,
    MUL_VEL_DRAG = 3'd4,
    MUL_VEL_LIM  = 3'd5
  } mul_sel_e;

  typedef enum logic [2:0] {
    VEL_NONE    = 3'd0,
    VEL_ADD_ACC = 3'd1,
    VEL_SUB_Q   = 3'd2,
    VEL_SET_Q   = 3'd3,
    VEL_ZERO    = 3'd4
  } vel_op_e;

  typedef struct packed {
    logic     cap;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     div_start;
    logic     div_acc;
    logic     acc_ld;
    logic     sqrt_start;
    logic     sq_ld;
    logic     sq_first;
    vel_op_e  vel_op;
    logic     speed_ld;
    logic     dlen_ld;
    logic     lim_ld;
    logic     clamp_set;
    logic     out_ld;
    comp_t    idx;
  } pmvi_cmd_t;

  typedef struct packed {
    logic frozen;
    logic div_busy;
    logic sqrt_busy;
    logic speed_zero;
    logic drag_gt;
    logic speed_gt_lim;
  } pmvi_sts_t;

  // Saturate a sign-extended W+2 bit sum to W bits
  function automatic logic [W-1:0] sat_w(input logic [W+1:0] v);
    logic [W-1:0] r;
    if (!v[W+1] && (v[W:W-1] != 2'b00)) begin
      r = {1'b0, {(W-1){1'b1}}};
    end else if (v[W+1] && (v[W:W-1] != 2'b11)) begin
      r = {1'b1, {(W-1){1'b0}}};
    end else begin
      r = v[W-1:0];
    end
    return r;
  endfunction

  function automatic logic [W+1:0] sext2(input logic [W-1:0] v);
    return {{2{v[W-1]}}, v};
  endfunction

endpackage

// ===== hdl/pmvi_div.sv =====
`timescale 1ns / 1ps

module pmvi_div import pmvi_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [W-1:0]     den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [W-1:0]     den_q, rem_q, rem_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [W:0]       sh, diff;

  // Restoring division, one quotient bit a cycle
  always_comb begin
    sh   = {rem_q, quo_q[NUM_W-1]};
    diff = sh - {1'b0, den_q};
    if (sh >= {1'b0, den_q}) begin
      rem_d = diff[W-1:0];
      quo_d = {quo_q[NUM_W-2:0], 1'b1};
    end else begin
      rem_d = sh[W-1:0];
      quo_d = {quo_q[NUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_W'(NUM_W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= num_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule

// ===== hdl/pmvi_sqrt.sv =====
`timescale 1ns / 1ps

module pmvi_sqrt import pmvi_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] rad_i,
  output logic             busy_o,
  output logic [W-1:0]     root_o
);

  localparam int CNT_W = $clog2(W);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] x_q;
  logic [W+2:0]     rem_q, rem_d, rem_sh, trial;
  logic [W-1:0]     root_q, root_d;

  // Digit-by-digit root, one result bit a cycle
  always_comb begin
    rem_sh = {rem_q[W:0], x_q[NUM_W-1:NUM_W-2]};
    trial  = {1'b0, root_q, 2'b01};
    if (rem_sh >= trial) begin
      rem_d  = rem_sh - trial;
      root_d = {root_q[W-2:0], 1'b1};
    end else begin
      rem_d  = rem_sh;
      root_d = {root_q[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_W'(W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      x_q    <= {x_q[NUM_W-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

// ===== hdl/pmvi_dp.sv =====
`timescale 1ns / 1ps

module pmvi_dp import pmvi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pmvi_cmd_t            cmd_i,
  output pmvi_sts_t            sts_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [W-1:0]         cfg_data_i,
  input  logic signed [W-1:0]  force_x_i,
  input  logic signed [W-1:0]  force_y_i,
  input  logic signed [W-1:0]  force_z_i,
  input  logic signed [W-1:0]  pos_in_x_i,
  input  logic signed [W-1:0]  pos_in_y_i,
  input  logic signed [W-1:0]  pos_in_z_i,
  input  logic [DT_BITS-1:0]   delta_time_i,
  output logic signed [W-1:0]  pos_out_x_o,
  output logic signed [W-1:0]  pos_out_y_o,
  output logic signed [W-1:0]  pos_out_z_o,
  output logic signed [W-1:0]  vel_out_x_o,
  output logic signed [W-1:0]  vel_out_y_o,
  output logic signed [W-1:0]  vel_out_z_o,
  output logic                 speed_clamped_o
);

  localparam logic [63:0] MASS64  = 64'd1 << FRAC_BITS;
  localparam logic [63:0] MAXSP64 = MAX_SPEED_DEF << FRAC_BITS;
  localparam logic [63:0] GRAV64  =
    (GRAVITY_MICRO * (64'd1 << FRAC_BITS) + 64'd500000) / 64'd1000000;
  localparam logic [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] NEG_MAG = {1'b1, {(W-1){1'b0}}};

  logic [W-1:0] mass_q, drag_q, max_speed_q, grav_q;
  logic         grav_on_q, kin_q, active_q;

  logic [W-1:0]       force_q [3];
  logic [W-1:0]       pos_q   [3];
  logic [W-1:0]       vel_q   [3];
  logic [DT_BITS-1:0] dt_q;
  logic               frz_q, clamp_q;
  logic [W-1:0]       acc_q, speed_q, dlen_q, lim_q;
  logic [NUM_W-1:0]   prod_q, sumsq_q;
  logic [W-1:0]       pos_out_q [3];
  logic [W-1:0]       vel_out_q [3];
  logic               clamp_out_q;

  logic [W-1:0]     f_cur, f_mag, v_cur, v_mag, acc_mag, mass_eff;
  logic [W-1:0]     mul_a, mul_b, acc_s, acc_d, q32, mstep;
  logic [NUM_W-1:0] mul_p, div_num, div_q;
  logic [W-1:0]     div_den, root;
  logic             div_busy, sqrt_busy;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_q      <= MASS64[W-1:0];
      drag_q      <= '0;
      max_speed_q <= MAXSP64[W-1:0];
      grav_on_q   <= 1'b0;
      grav_q      <= GRAV64[W-1:0];
      kin_q       <= 1'b0;
      active_q    <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MASS:       mass_q      <= cfg_data_i;
        CFG_DRAG:       drag_q      <= cfg_data_i;
        CFG_MAX_SPEED:  max_speed_q <= cfg_data_i;
        CFG_GRAVITY_ON: grav_on_q   <= cfg_data_i[0];
        CFG_GRAVITY:    grav_q      <= cfg_data_i;
        CFG_KINEMATIC:  kin_q       <= cfg_data_i[0];
        CFG_ACTIVE:     active_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    f_cur    = force_q[cmd_i.idx];
    f_mag    = f_cur[W-1] ? (W'(0) - f_cur) : f_cur;
    v_cur    = vel_q[cmd_i.idx];
    v_mag    = v_cur[W-1] ? (W'(0) - v_cur) : v_cur;
    acc_mag  = acc_q[W-1] ? (W'(0) - acc_q) : acc_q;
    mass_eff = (mass_q == '0) ? W'(1) : mass_q;
    q32      = div_q[W-1:0];
    mstep    = prod_q[DT_BITS+W-1:DT_BITS];
  end

  // Shared multiplier operand select
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_ACC_DT: begin
        mul_a = acc_mag;
        mul_b = W'(dt_q);
      end
      MUL_VEL_SQ: begin
        mul_a = v_mag;
        mul_b = v_mag;
      end
      MUL_DRAG_DT: begin
        mul_a = drag_q;
        mul_b = W'(dt_q);
      end
      MUL_LIM_DT: begin
        mul_a = max_speed_q;
        mul_b = W'(dt_q);
      end
      MUL_VEL_DRAG: begin
        mul_a = v_mag;
        mul_b = dlen_q;
      end
      MUL_VEL_LIM: begin
        mul_a = v_mag;
        mul_b = lim_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = NUM_W'(mul_a) * NUM_W'(mul_b);
  end

  assign div_num = cmd_i.div_acc ? (NUM_W'(f_mag) << FRAC_BITS) : prod_q;
  assign div_den = cmd_i.div_acc ? mass_eff : speed_q;

  pmvi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quot_o  (div_q)
  );

  pmvi_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .rad_i   (sumsq_q),
    .busy_o  (sqrt_busy),
    .root_o  (root)
  );

  // Saturate the quotient to a signed acceleration, then add gravity on y when gravity is on
  always_comb begin
    if (!f_cur[W-1]) begin
      acc_s = (div_q > NUM_W'(POS_MAX)) ? POS_MAX : q32;
    end else begin
      acc_s = (div_q > NUM_W'(NEG_MAG)) ? NEG_MAG : (W'(0) - q32);
    end
    if (grav_on_q && (cmd_i.idx == COMP_Y)) begin
      acc_d = sat_w(sext2(acc_s) + {2'b00, grav_q});
    end else begin
      acc_d = acc_s;
    end
  end

  // Velocity state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        vel_q[i] <= '0;
      end
    end else begin
      case (cmd_i.vel_op)
        VEL_ADD_ACC: vel_q[cmd_i.idx] <= acc_q[W-1] ?
                       sat_w(sext2(v_cur) - {2'b00, mstep}) :
                       sat_w(sext2(v_cur) + {2'b00, mstep});
        VEL_SUB_Q:   vel_q[cmd_i.idx] <= v_cur[W-1] ? (v_cur + q32) : (v_cur - q32);
        VEL_SET_Q:   vel_q[cmd_i.idx] <= v_cur[W-1] ? (W'(0) - q32) : q32;
        VEL_ZERO: begin
          for (int i = 0; i < 3; i++) begin
            vel_q[i] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      force_q[0] <= force_x_i;
      force_q[1] <= force_y_i;
      force_q[2] <= force_z_i;
      pos_q[0]   <= pos_in_x_i;
      pos_q[1]   <= pos_in_y_i;
      pos_q[2]   <= pos_in_z_i;
      dt_q       <= delta_time_i;
      frz_q      <= !active_q || kin_q;
    end
    if (cmd_i.cap) begin
      clamp_q <= 1'b0;
    end else if (cmd_i.clamp_set) begin
      clamp_q <= 1'b1;
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_p;
    end
    if (cmd_i.acc_ld) begin
      acc_q <= acc_d;
    end
    if (cmd_i.sq_ld) begin
      sumsq_q <= cmd_i.sq_first ? prod_q : (sumsq_q + prod_q);
    end
    if (cmd_i.speed_ld) begin
      speed_q <= root;
    end
    if (cmd_i.dlen_ld) begin
      dlen_q <= mstep;
    end
    if (cmd_i.lim_ld) begin
      lim_q <= mstep;
    end
    if (cmd_i.out_ld) begin
      for (int i = 0; i < 3; i++) begin
        pos_out_q[i] <= frz_q ? pos_q[i] : sat_w(sext2(pos_q[i]) + sext2(vel_q[i]));
        vel_out_q[i] <= vel_q[i];
      end
      clamp_out_q <= clamp_q;
    end
  end

  assign sts_o.frozen       = !active_q || kin_q;
  assign sts_o.div_busy     = div_busy;
  assign sts_o.sqrt_busy    = sqrt_busy;
  assign sts_o.speed_zero   = (speed_q == '0);
  assign sts_o.drag_gt      = (dlen_q > speed_q);
  assign sts_o.speed_gt_lim = (speed_q > lim_q);

  assign pos_out_x_o     = pos_out_q[0];
  assign pos_out_y_o     = pos_out_q[1];
  assign pos_out_z_o     = pos_out_q[2];
  assign vel_out_x_o     = vel_out_q[0];
  assign vel_out_y_o     = vel_out_q[1];
  assign vel_out_z_o     = vel_out_q[2];
  assign speed_clamped_o = clamp_out_q;

endmodule

// ===== hdl/pmvi_ctrl.sv =====
`timescale 1ns / 1ps

module pmvi_ctrl import pmvi_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output pmvi_cmd_t cmd_o,
  input  pmvi_sts_t sts_i
);

  typedef enum logic [18:0] {
    S_IDLE  = 19'h00001,
    S_ADIV  = 19'h00002,
    S_AWAIT = 19'h00004,
    S_AMUL  = 19'h00008,
    S_VADD  = 19'h00010,
    S_SQM   = 19'h00020,
    S_SQA   = 19'h00040,
    S_RTGO  = 19'h00080,
    S_RTW   = 19'h00100,
    S_DMUL  = 19'h00200,
    S_DLD   = 19'h00400,
    S_DCHK  = 19'h00800,
    S_LMUL  = 19'h01000,
    S_LLD   = 19'h02000,
    S_LCHK  = 19'h04000,
    S_SCM   = 19'h08000,
    S_SCD   = 19'h10000,
    S_SCW   = 19'h20000,
    S_OUT   = 19'h40000
  } state_e;

  state_e    state_q, state_d;
  comp_t     idx_q, idx_d;
  logic      ph_q, ph_d;
  logic      out_valid_q, out_valid_d;
  pmvi_cmd_t cmd;
  logic      last;

  assign last = (idx_q == COMP_LAST);

  always_comb begin
    cmd      = '0;
    cmd.idx  = idx_q;
    state_d  = state_q;
    idx_d    = idx_q;
    ph_d     = ph_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.cap = 1'b1;
          idx_d   = COMP_FIRST;
          ph_d    = 1'b0;
          state_d = sts_i.frozen ? S_OUT : S_ADIV;
        end
      end
      S_ADIV: begin
        cmd.div_start = 1'b1;
        cmd.div_acc   = 1'b1;
        state_d       = S_AWAIT;
      end
      S_AWAIT: begin
        if (!sts_i.div_busy) begin
          cmd.acc_ld = 1'b1;
          state_d    = S_AMUL;
        end
      end
      S_AMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_ACC_DT;
        state_d     = S_VADD;
      end
      S_VADD: begin
        cmd.vel_op = VEL_ADD_ACC;
        if (last) begin
          idx_d   = COMP_FIRST;
          state_d = S_SQM;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_ADIV;
        end
      end
      S_SQM: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_VEL_SQ;
        state_d     = S_SQA;
      end
      S_SQA: begin
        cmd.sq_ld    = 1'b1;
        cmd.sq_first = (idx_q == COMP_FIRST);
        if (last) begin
          idx_d   = COMP_FIRST;
          state_d = S_RTGO;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_SQM;
        end
      end
      S_RTGO: begin
        cmd.sqrt_start = 1'b1;
        state_d        = S_RTW;
      end
      S_RTW: begin
        if (!sts_i.sqrt_busy) begin
          cmd.speed_ld = 1'b1;
          state_d      = ph_q ? S_LMUL : S_DMUL;
        end
      end
      S_DMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DRAG_DT;
        state_d     = S_DLD;
      end
      S_DLD: begin
        cmd.dlen_ld = 1'b1;
        state_d     = S_DCHK;
      end
      S_DCHK: begin
        idx_d = COMP_FIRST;
        if (sts_i.speed_zero) begin
          ph_d    = 1'b1;
          state_d = S_LMUL;
        end else if (sts_i.drag_gt) begin
          cmd.vel_op = VEL_ZERO;
          ph_d       = 1'b1;
          state_d    = S_SQM;
        end else begin
          state_d = S_SCM;
        end
      end
      S_LMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_LIM_DT;
        state_d     = S_LLD;
      end
      S_LLD: begin
        cmd.lim_ld = 1'b1;
        state_d    = S_LCHK;
      end
      S_LCHK: begin
        if (sts_i.speed_gt_lim) begin
          cmd.clamp_set = 1'b1;
          idx_d         = COMP_FIRST;
          state_d       = S_SCM;
        end else begin
          state_d = S_OUT;
        end
      end
      S_SCM: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = ph_q ? MUL_VEL_LIM : MUL_VEL_DRAG;
        state_d     = S_SCD;
      end
      S_SCD: begin
        cmd.div_start = 1'b1;
        state_d       = S_SCW;
      end
      S_SCW: begin
        if (!sts_i.div_busy) begin
          cmd.vel_op = ph_q ? VEL_SET_Q : VEL_SUB_Q;
          if (!last) begin
            idx_d   = idx_q + 1'b1;
            state_d = S_SCM;
          end else if (ph_q) begin
            state_d = S_OUT;
          end else begin
            ph_d    = 1'b1;
            idx_d   = COMP_FIRST;
            state_d = S_SQM;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd.out_ld = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_ld) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= COMP_FIRST;
      ph_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      ph_q        <= ph_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> !sts_i.div_busy)
    else $error("divider started while busy");

  a_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second item taken before the first finished");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_ld |-> (!out_valid_q || !out_stall_i))
    else $error("result overwrote a pending item");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q == COMP_FIRST) || (idx_q == COMP_Y) || (idx_q == COMP_LAST))
    else $error("component index out of range");

endmodule

// ===== hdl/point_mass_velocity_integrator.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake               Payload
// input     in         in_valid_i/in_stall_o   force_x/y/z, pos_in_x/y/z, delta_time
// output    out        out_valid_o/out_stall_i pos_out_x/y/z, vel_out_x/y/z, speed_clamped
// config    in         cfg_we_i (no handshake) cfg_idx_i, cfg_data_i
//
// One item at a time. A frozen body (inactive or kinematic) goes from capture
// straight to the output step. An active body skips all rescaling while its
// velocity stays zero; once it moves, the drag step rescales every nonzero
// velocity, even at zero drag, and the speed limit can rescale it again. Each
// division runs on the shared bit-serial divider (three for acceleration, up to
// six for rescaling) and each speed is a bit-serial root. Reset clears the
// velocity and loads the register defaults. A result waits in the output
// register under stall while the next item is already accepted and worked on.

module point_mass_velocity_integrator import pmvi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [W-1:0]         cfg_data_i,
  input  logic signed [W-1:0]  force_x_i,
  input  logic signed [W-1:0]  force_y_i,
  input  logic signed [W-1:0]  force_z_i,
  input  logic signed [W-1:0]  pos_in_x_i,
  input  logic signed [W-1:0]  pos_in_y_i,
  input  logic signed [W-1:0]  pos_in_z_i,
  input  logic [DT_BITS-1:0]   delta_time_i,
  output logic signed [W-1:0]  pos_out_x_o,
  output logic signed [W-1:0]  pos_out_y_o,
  output logic signed [W-1:0]  pos_out_z_o,
  output logic signed [W-1:0]  vel_out_x_o,
  output logic signed [W-1:0]  vel_out_y_o,
  output logic signed [W-1:0]  vel_out_z_o,
  output logic                 speed_clamped_o
);

  pmvi_cmd_t cmd;
  pmvi_sts_t sts;

  // Sequencer: walks acceleration, speed, drag, limit and output steps
  pmvi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Datapath: registers, velocity state, multiplier, divider and root
  pmvi_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .force_x_i       (force_x_i),
    .force_y_i       (force_y_i),
    .force_z_i       (force_z_i),
    .pos_in_x_i      (pos_in_x_i),
    .pos_in_y_i      (pos_in_y_i),
    .pos_in_z_i      (pos_in_z_i),
    .delta_time_i    (delta_time_i),
    .pos_out_x_o     (pos_out_x_o),
    .pos_out_y_o     (pos_out_y_o),
    .pos_out_z_o     (pos_out_z_o),
    .vel_out_x_o     (vel_out_x_o),
    .vel_out_y_o     (vel_out_y_o),
    .vel_out_z_o     (vel_out_z_o),
    .speed_clamped_o (speed_clamped_o)
  );

endmodule
